/* rtl/core/far_pkg.sv */
// Shared widths and operation codes for the fraction accumulator.
`default_nettype none

package far_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned OpW   = 2;
  localparam int unsigned CntW  = $clog2(DataW);

  typedef logic [OpW-1:0]          op_t;
  typedef logic signed [DataW-1:0] word_t;

  localparam op_t OpLoad   = 2'd0;
  localparam op_t OpAdd    = 2'd1;
  localparam op_t OpMul    = 2'd2;
  localparam op_t OpReduce = 2'd3;

  // start/done pair between the sequencer and an iterative unit
  typedef struct packed {
    logic start;
  } unit_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_rsp_t;

endpackage

`default_nettype wire

/* rtl/core/far_if.sv */
// Valid/ready channel interfaces for operation requests and results.
`default_nettype none

interface far_in_if;
  import far_pkg::*;
  logic  valid;
  logic  ready;
  op_t   operation;
  word_t operand_num;
  word_t operand_den;

  modport source (output valid, output operation, output operand_num, output operand_den,
                  input ready);
  modport sink   (input valid, input operation, input operand_num, input operand_den,
                  output ready);
endinterface

interface far_out_if;
  import far_pkg::*;
  logic  valid;
  logic  ready;
  word_t result_num;
  word_t result_den;
  logic  overflow;

  modport source (output valid, output result_num, output result_den, output overflow,
                  input ready);
  modport sink   (input valid, input result_num, input result_den, input overflow,
                  output ready);
endinterface

`default_nettype wire

/* rtl/core/far_gcd.sv */
// Binary gcd unit: one shift or one compare-subtract per cycle.
`default_nettype none

module far_gcd (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  far_pkg::unit_req_t            req_i,
  input  logic [far_pkg::DataW-1:0]     a_i,
  input  logic [far_pkg::DataW-1:0]     b_i,
  output far_pkg::unit_rsp_t            rsp_o,
  output logic [far_pkg::DataW-1:0]     g_o
);
  import far_pkg::*;

  logic [DataW-1:0] a_q, a_d, b_q, b_d;
  logic [CntW-1:0]  k_q, k_d;
  logic             busy_q, busy_d;
  logic [DataW:0]   diff;
  logic             finish;

  assign diff   = {1'b0, a_q} - {1'b0, b_q};
  assign finish = busy_q && ((a_q == '0) || (b_q == '0));

  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    k_d    = k_q;
    busy_d = busy_q;
    if (req_i.start) begin
      a_d    = a_i;
      b_d    = b_i;
      k_d    = '0;
      busy_d = 1'b1;
    end else if (finish) begin
      busy_d = 1'b0;
    end else if (busy_q) begin
      priority if (!a_q[0] && !b_q[0]) begin
        // common factor of two, only before the first odd value shows up
        a_d = a_q >> 1;
        b_d = b_q >> 1;
        k_d = k_q + 1'b1;
      end else if (!a_q[0]) begin
        a_d = a_q >> 1;
      end else if (!b_q[0]) begin
        b_d = b_q >> 1;
      end else if (!diff[DataW]) begin
        a_d = diff[DataW-1:0];
      end else begin
        b_d = b_q - a_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      k_q    <= '0;
    end else begin
      busy_q <= busy_d;
      k_q    <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
  end

  assign g_o        = (a_q | b_q) << k_q;
  assign rsp_o.busy = busy_q;
  assign rsp_o.done = finish;

endmodule

`default_nettype wire

/* rtl/core/far_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none

module far_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  far_pkg::unit_req_t            req_i,
  input  logic [far_pkg::DataW-1:0]     dividend_i,
  input  logic [far_pkg::DataW-1:0]     divisor_i,
  output far_pkg::unit_rsp_t            rsp_o,
  output logic [far_pkg::DataW-1:0]     quot_o
);
  import far_pkg::*;

  logic [DataW-1:0] rem_q, dvd_q, dvs_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q, done_q;
  logic [DataW:0]   rem_sh, diff;
  logic             qbit;

  assign rem_sh = {rem_q, dvd_q[DataW-1]};
  assign diff   = rem_sh - {1'b0, dvs_q};
  assign qbit   = !diff[DataW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(DataW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= qbit ? diff[DataW-1:0] : rem_sh[DataW-1:0];
      dvd_q <= {dvd_q[DataW-2:0], qbit};
    end
  end

  assign quot_o     = dvd_q;
  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;

endmodule

`default_nettype wire

/* rtl/core/fraction_accumulator_reduce.sv */
// Top level: fraction accumulator with multiply sequencer, gcd and divide units.
// Keeps one fraction num/den (reset 0/1) and answers every transaction with the
// stored fraction and an overflow flag. A load's result is presented in the cycle
// after acceptance. Multiply runs two products through the single 32x32
// multiplier, add runs three products plus the wrapped sum. After add, multiply
// or reduce, when both parts are at least 1 the fraction is reduced: the binary
// gcd unit takes one shift or subtract step per cycle, then the shared restoring
// divider runs twice, once for the numerator and once for the denominator. The
// block takes no new transaction until the result has been taken.
`default_nettype none

module fraction_accumulator_reduce (
  input  logic      clk_i,
  input  logic      rst_ni,
  far_in_if.sink    in_i,
  far_out_if.source out_o
);
  import far_pkg::*;

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SMulA = 3'd1;
  localparam logic [2:0] SMulB = 3'd2;
  localparam logic [2:0] SChk  = 3'd3;
  localparam logic [2:0] SGcd  = 3'd4;
  localparam logic [2:0] SDivN = 3'd5;
  localparam logic [2:0] SDivD = 3'd6;
  localparam logic [2:0] SOut  = 3'd7;

  logic [2:0]          state_q;
  op_t                 op_q;
  logic [1:0]          mstep_q;
  logic                ovf_q;
  word_t               acc_num_q, acc_den_q;
  word_t               num_q, den_q, n2_q, d2_q;
  logic signed [2*DataW-1:0] prod_q;

  word_t               opa, opb;
  logic [DataW-1:0]    wrapped;
  logic [DataW:0]      sum;
  logic                prod_ovf, last_step, both_pos, accept;

  unit_req_t           gcd_req, div_req;
  unit_rsp_t           gcd_rsp, div_rsp;
  logic [DataW-1:0]    gcd_g, div_quot, div_dvd;

  assign accept = in_i.valid && in_i.ready;

  // operand selection for the shared multiplier
  always_comb begin
    unique case (mstep_q)
      2'd0:    begin opa = acc_den_q; opb = d2_q; end
      2'd1:    begin opa = acc_num_q; opb = (op_q == OpAdd) ? d2_q : n2_q; end
      default: begin opa = n2_q;      opb = acc_den_q; end
    endcase
  end

  assign wrapped   = prod_q[DataW-1:0];
  assign prod_ovf  = prod_q[2*DataW-1:DataW-1] != {(DataW+1){prod_q[DataW-1]}};
  assign sum       = {num_q[DataW-1], num_q} + {wrapped[DataW-1], wrapped};
  assign last_step = (op_q == OpAdd) ? (mstep_q == 2'd2) : (mstep_q == 2'd1);
  assign both_pos  = !num_q[DataW-1] && (num_q != '0) && !den_q[DataW-1] && (den_q != '0);

  assign gcd_req.start = (state_q == SChk) && both_pos;
  assign div_req.start = ((state_q == SGcd) && gcd_rsp.done) ||
                         ((state_q == SDivN) && div_rsp.done);
  assign div_dvd       = (state_q == SGcd) ? num_q : den_q;

  far_gcd u_gcd (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (gcd_req),
    .a_i    (num_q),
    .b_i    (den_q),
    .rsp_o  (gcd_rsp),
    .g_o    (gcd_g)
  );

  far_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .dividend_i (div_dvd),
    .divisor_i  (gcd_g),
    .rsp_o      (div_rsp),
    .quot_o     (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SIdle;
      mstep_q   <= '0;
      ovf_q     <= 1'b0;
      op_q      <= OpLoad;
      acc_num_q <= '0;
      acc_den_q <= word_t'(1);
    end else begin
      unique case (state_q)
        SIdle: begin
          if (accept) begin
            op_q    <= in_i.operation;
            ovf_q   <= 1'b0;
            mstep_q <= '0;
            unique case (in_i.operation)
              OpLoad:   state_q <= SOut;
              OpReduce: state_q <= SChk;
              default:  state_q <= SMulA;
            endcase
          end
        end
        SMulA: state_q <= SMulB;
        SMulB: begin
          if (prod_ovf || ((mstep_q == 2'd2) && (sum[DataW] != sum[DataW-1]))) begin
            ovf_q <= 1'b1;
          end
          if (last_step) begin
            state_q <= SChk;
          end else begin
            mstep_q <= mstep_q + 1'b1;
            state_q <= SMulA;
          end
        end
        SChk:  state_q <= both_pos ? SGcd : SOut;
        SGcd:  if (gcd_rsp.done) state_q <= SDivN;
        SDivN: if (div_rsp.done) state_q <= SDivD;
        SDivD: if (div_rsp.done) state_q <= SOut;
        SOut: begin
          if (out_o.ready) begin
            acc_num_q <= num_q;
            acc_den_q <= den_q;
            state_q   <= SIdle;
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      n2_q <= in_i.operand_num;
      d2_q <= in_i.operand_den;
      if (in_i.operation == OpLoad) begin
        num_q <= in_i.operand_num;
        den_q <= in_i.operand_den;
      end else begin
        num_q <= acc_num_q;
        den_q <= acc_den_q;
      end
    end else if (state_q == SMulB) begin
      unique case (mstep_q)
        2'd0:    den_q <= wrapped;
        2'd1:    num_q <= wrapped;
        default: num_q <= sum[DataW-1:0];
      endcase
    end else if ((state_q == SDivN) && div_rsp.done) begin
      num_q <= div_quot;
    end else if ((state_q == SDivD) && div_rsp.done) begin
      den_q <= div_quot;
    end
    if (state_q == SMulA) begin
      prod_q <= opa * opb;
    end
  end

  assign in_i.ready       = (state_q == SIdle);
  assign out_o.valid      = (state_q == SOut);
  assign out_o.result_num = num_q;
  assign out_o.result_den = den_q;
  assign out_o.overflow   = ovf_q;

  a_ready_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !out_o.valid)
    else $error("input ready while a result is pending");

  a_load_direct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_i.operation == OpLoad)) |=> out_o.valid)
    else $error("load did not present its result at once");

  a_no_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && ((op_q == OpLoad) || (op_q == OpReduce))) |-> !out_o.overflow)
    else $error("overflow flagged for load or reduce");

  a_units_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SIdle) |-> (!gcd_rsp.busy && !div_rsp.busy))
    else $error("arithmetic unit busy while idle");

endmodule

`default_nettype wire

/* tb/sv/tb_fraction_accumulator_reduce.sv */
// Self-checking testbench for fraction_accumulator_reduce: directed table, random ops, predictor.
module tb_fraction_accumulator_reduce;
  timeunit 1ns;
  timeprecision 1ps;

  import far_pkg::*;

  localparam word_t WordMax   = 32'sh7FFF_FFFF;
  localparam word_t WordMin   = 32'sh8000_0000;
  localparam int    DirRows   = 25;
  localparam int    RandItems = 1230;
  localparam int    TailWait  = 200;

  typedef struct {
    word_t num;
    word_t den;
    logic  ovf;
  } frac_t;

  typedef struct {
    op_t   op;
    word_t num;
    word_t den;
    bit    known;
    frac_t typed;
  } stim_row_t;

  logic clk;
  logic rst_n;

  far_in_if  in_ch ();
  far_out_if out_ch ();

  fraction_accumulator_reduce uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  // predictor state, mirrors the stored fraction
  word_t frac_num;
  word_t frac_den;

  frac_t     frac_q[$];
  int        mismatches;
  int        tx_idle_pct;
  int        rx_idle_pct;
  stim_row_t dir_rows[DirRows];

  always #5 clk = ~clk;

  function automatic bit beyond_word(input longint v);
    return (v < longint'(WordMin)) || (v > longint'(WordMax));
  endfunction

  function automatic word_t wrap_word(input longint v);
    return word_t'(v[31:0]);
  endfunction

  function automatic logic [31:0] gcd_of(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  function automatic void reduce_frac();
    logic [31:0] g;
    if (frac_num >= 1 && frac_den >= 1) begin
      g = gcd_of(frac_num, frac_den);
      frac_num = word_t'(32'(frac_num) / g);
      frac_den = word_t'(32'(frac_den) / g);
    end
  endfunction

  function automatic frac_t predict_fraction(input op_t op, input word_t n2, input word_t d2);
    longint pa, pb, pd, s;
    frac_t  r;
    r.ovf = 1'b0;
    case (op)
      OpLoad: begin
        frac_num = n2;
        frac_den = d2;
      end
      OpAdd: begin
        pd = longint'(frac_den) * longint'(d2);
        pa = longint'(frac_num) * longint'(d2);
        pb = longint'(n2) * longint'(frac_den);
        r.ovf = beyond_word(pd) || beyond_word(pa) || beyond_word(pb);
        // sum is built from the already wrapped products
        s = longint'(wrap_word(pa)) + longint'(wrap_word(pb));
        if (beyond_word(s)) r.ovf = 1'b1;
        frac_num = wrap_word(s);
        frac_den = wrap_word(pd);
        reduce_frac();
      end
      OpMul: begin
        pa = longint'(frac_num) * longint'(n2);
        pd = longint'(frac_den) * longint'(d2);
        r.ovf = beyond_word(pa) || beyond_word(pd);
        frac_num = wrap_word(pa);
        frac_den = wrap_word(pd);
        reduce_frac();
      end
      default: begin
        reduce_frac();
      end
    endcase
    r.num = frac_num;
    r.den = frac_den;
    return r;
  endfunction

  function automatic word_t rand_operand();
    int r;
    r = $urandom_range(99);
    if (r < 55) begin
      // small values keep reductions frequent and products in range
      if ($urandom_range(99) < 12) return -word_t'($urandom_range(40));
      return word_t'($urandom_range(40));
    end else if (r < 80) begin
      return word_t'($urandom_range(65535, 1));
    end else if (r < 90) begin
      return word_t'($urandom);
    end
    case ($urandom_range(5))
      0: return WordMax;
      1: return WordMin;
      2: return -1;
      3: return 0;
      4: return 1;
      default: return 32'sh4000_0000;
    endcase
  endfunction

  function automatic op_t rand_op();
    int r;
    r = $urandom_range(99);
    if (r < 20) return OpLoad;
    if (r < 50) return OpAdd;
    if (r < 80) return OpMul;
    return OpReduce;
  endfunction

  task automatic send_op(input op_t op, input word_t num, input word_t den,
                         input bit known, input frac_t typed);
    frac_t predicted;
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid       <= 1'b1;
    in_ch.operation   <= op;
    in_ch.operand_num <= num;
    in_ch.operand_den <= den;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predicted = predict_fraction(op, num, den);
    frac_q.push_back(known ? typed : predicted);
  endtask

  // hold the sender off until every pending result is back
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (frac_q.size() != 0) @(posedge clk);
  endtask

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    frac_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (frac_q.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result transaction: %0d/%0d ovf=%0b",
                   out_ch.result_num, out_ch.result_den, out_ch.overflow);
        mismatches++;
      end else begin
        want = frac_q.pop_front();
        if (out_ch.result_num !== want.num || out_ch.result_den !== want.den ||
            out_ch.overflow !== want.ovf) begin
          if (mismatches < 10)
            $display("mismatch at %0t: expected %0d/%0d ovf=%0b, got %0d/%0d ovf=%0b",
                     $realtime, want.num, want.den, want.ovf,
                     out_ch.result_num, out_ch.result_den, out_ch.overflow);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("FAIL fraction_accumulator_reduce");
    $finish;
  end

  initial begin
    frac_t nil;
    int    phase;
    nil = '{num: 0, den: 0, ovf: 1'b0};

    dir_rows[0]  = '{OpReduce, 32'shA5A5_A5A5, 32'sh5A5A_5A5A, 1, '{0, 1, 1'b0}};
    dir_rows[1]  = '{OpLoad,   6,          4,          1, '{6, 4, 1'b0}};
    dir_rows[2]  = '{OpReduce, -1,         -1,         1, '{3, 2, 1'b0}};
    dir_rows[3]  = '{OpAdd,    1,          2,          1, '{2, 1, 1'b0}};
    dir_rows[4]  = '{OpMul,    3,          4,          1, '{3, 2, 1'b0}};
    dir_rows[5]  = '{OpLoad,   WordMax,    WordMax,    1, '{WordMax, WordMax, 1'b0}};
    dir_rows[6]  = '{OpMul,    WordMax,    WordMax,    1, '{1, 1, 1'b1}};
    dir_rows[7]  = '{OpLoad,   WordMin,    -1,         1, '{WordMin, -1, 1'b0}};
    dir_rows[8]  = '{OpMul,    -1,         -1,         1, '{WordMin, 1, 1'b1}};
    dir_rows[9]  = '{OpAdd,    WordMin,    WordMin,    0, nil};
    dir_rows[10] = '{OpLoad,   5,          0,          1, '{5, 0, 1'b0}};
    dir_rows[11] = '{OpAdd,    3,          7,          0, nil};
    dir_rows[12] = '{OpReduce, 0,          0,          1, '{35, 0, 1'b0}};
    dir_rows[13] = '{OpLoad,   -6,         4,          1, '{-6, 4, 1'b0}};
    dir_rows[14] = '{OpReduce, WordMax,    WordMin,    1, '{-6, 4, 1'b0}};
    dir_rows[15] = '{OpMul,    -1,         1,          0, nil};
    dir_rows[16] = '{OpLoad,   WordMax,    1,          1, '{WordMax, 1, 1'b0}};
    dir_rows[17] = '{OpAdd,    1,          1,          1, '{WordMin, 1, 1'b1}};
    // consecutive Fibonacci numbers: coprime, long gcd run
    dir_rows[18] = '{OpLoad,   1836311903, 1134903170, 1, '{1836311903, 1134903170, 1'b0}};
    dir_rows[19] = '{OpReduce, 0,          0,          0, nil};
    dir_rows[20] = '{OpLoad,   32'sh4000_0000, 32'sh2000_0000, 1,
                     '{32'sh4000_0000, 32'sh2000_0000, 1'b0}};
    dir_rows[21] = '{OpReduce, 0,          0,          1, '{2, 1, 1'b0}};
    dir_rows[22] = '{OpLoad,   1,          1,          1, '{1, 1, 1'b0}};
    dir_rows[23] = '{OpMul,    0,          5,          0, nil};
    dir_rows[24] = '{OpAdd,    -3,         5,          0, nil};

    clk               = 1'b0;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.operation   = OpLoad;
    in_ch.operand_num = '0;
    in_ch.operand_den = '0;
    out_ch.ready      = 1'b0;
    mismatches        = 0;
    tx_idle_pct       = 8;
    rx_idle_pct       = 77;
    frac_num          = 0;
    frac_den          = 1;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      send_op(dir_rows[i].op, dir_rows[i].num, dir_rows[i].den,
              dir_rows[i].known, dir_rows[i].typed);
    drain_results();

    for (int n = 0; n < RandItems; n++) begin
      phase = n / (RandItems / 3);
      case (phase)
        0: begin
          tx_idle_pct = 8;
          rx_idle_pct = 77;
        end
        1: begin
          tx_idle_pct = 77;
          rx_idle_pct = 8;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      send_op(rand_op(), rand_operand(), rand_operand(), 1'b0, nil);
      if ($urandom_range(99) == 0) drain_results();
    end

    drain_results();
    repeat (TailWait) @(posedge clk);

    if (mismatches == 0 && frac_q.size() == 0) begin
      $display("PASS fraction_accumulator_reduce");
    end else begin
      $display("FAIL fraction_accumulator_reduce");
    end
    $finish;
  end

endmodule
